// File: design/kdclp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdclp_pkg
// Shared types and constants for the button debounce and click/long-press unit.
// ----------------------------------------------------------------------------
package kdclp_pkg;

    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_W-1:0]       cfg_data_t;

    // register indexes on the configuration channel
    localparam cfg_index_t REG_DEBOUNCE_TICKS   = 2'd0;
    localparam cfg_index_t REG_LONG_PRESS_TICKS = 2'd1;

    localparam cfg_data_t DEBOUNCE_TICKS_RST   = 16'd50;
    localparam cfg_data_t LONG_PRESS_TICKS_RST = 16'd800;

    // debouncer result for one item
    typedef struct packed {
        logic level_ready;
        logic stable_level;
    } dbnc_status_t;

    // press classifier result for one item
    typedef struct packed {
        logic click_flag;
        logic long_flag;
        logic press_held;
    } press_status_t;

endpackage

// File: design/kdclp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdclp interfaces
// Valid/ready channels for key samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface kdclp_in_if;
    logic valid;
    logic ready;
    logic key_level;
    logic ack_click;
    logic ack_long;

    modport source (output valid, output key_level, output ack_click, output ack_long,
                    input ready);
    modport sink   (input valid, input key_level, input ack_click, input ack_long,
                    output ready);
endinterface

interface kdclp_out_if;
    logic valid;
    logic ready;
    logic click_flag;
    logic long_flag;
    logic stable_level;
    logic level_ready;
    logic press_held;

    modport source (output valid, output click_flag, output long_flag, output stable_level,
                    output level_ready, output press_held, input ready);
    modport sink   (input valid, input click_flag, input long_flag, input stable_level,
                    input level_ready, input press_held, output ready);
endinterface

interface kdclp_cfg_if;
    import kdclp_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/kdclp_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdclp_debounce
// Accepts a raw level once it has stayed unchanged for the debounce count.
// ----------------------------------------------------------------------------
module kdclp_debounce #(
    parameter int CountWidth = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    raw,
    input  kdclp_pkg::cfg_data_t    debounce_ticks,
    output kdclp_pkg::dbnc_status_t status
);
    import kdclp_pkg::*;

    localparam int CmpW = (CountWidth > CFG_W) ? CountWidth : CFG_W;

    logic                  last_raw_reg,  last_raw_next;
    logic [CountWidth-1:0] unchanged_reg, unchanged_next;
    logic                  fixed_reg,     fixed_next;
    logic                  debounced_reg, debounced_next;

    logic                  changed;
    logic [CountWidth-1:0] unchanged_inc;
    logic                  accept_level;

    always_comb
    begin
        changed       = (raw != last_raw_reg);
        unchanged_inc = (unchanged_reg == {CountWidth{1'b1}}) ? unchanged_reg
                        : unchanged_reg + CountWidth'(1);
        accept_level  = !changed && !fixed_reg
                        && (CmpW'(unchanged_inc) >= CmpW'(debounce_ticks));

        last_raw_next  = raw;
        unchanged_next = changed ? '0 : unchanged_inc;
        fixed_next     = changed ? 1'b0 : (fixed_reg | accept_level);
        debounced_next = accept_level ? raw : debounced_reg;

        status.level_ready  = accept_level;
        status.stable_level = debounced_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg  <= 1'b1;
            unchanged_reg <= '0;
            fixed_reg     <= 1'b0;
            debounced_reg <= 1'b1;
        end
        else if (step)
        begin
            last_raw_reg  <= last_raw_next;
            unchanged_reg <= unchanged_next;
            fixed_reg     <= fixed_next;
            debounced_reg <= debounced_next;
        end
    end

endmodule

// File: design/kdclp_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdclp_press
// Times an accepted press and latches a click or long-press flag.
// ----------------------------------------------------------------------------
module kdclp_press #(
    parameter int CountWidth = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  kdclp_pkg::dbnc_status_t  dbnc,
    input  logic                     ack_click,
    input  logic                     ack_long,
    input  kdclp_pkg::cfg_data_t     long_press_ticks,
    output kdclp_pkg::press_status_t status
);
    import kdclp_pkg::*;

    localparam int CmpW = (CountWidth > CFG_W) ? CountWidth : CFG_W;

    logic [CountWidth-1:0] hold_reg,  hold_next;
    logic                  push_reg,  push_next;
    logic                  click_reg, click_next;
    logic                  long_reg,  long_next;

    logic                  click_acked;
    logic [CountWidth-1:0] hold_inc;
    logic                  is_long;

    always_comb
    begin
        click_acked = click_reg & ~ack_click;
        click_next  = click_acked;
        long_next   = long_reg & ~ack_long;
        push_next   = push_reg;

        if (push_reg && (hold_reg != {CountWidth{1'b1}}))
            hold_inc = hold_reg + CountWidth'(1);
        else
            hold_inc = hold_reg;
        hold_next = hold_inc;
        is_long   = (CmpW'(hold_inc) >= CmpW'(long_press_ticks));

        if (dbnc.level_ready)
        begin
            if (!dbnc.stable_level)
            begin
                hold_next = '0;
                push_next = 1'b1;
            end
            // release classifies only when no click is still waiting
            else if (!click_acked && push_reg && !is_long)
            begin
                click_next = 1'b1;
                push_next  = 1'b0;
                long_next  = 1'b0;
            end
        end
        else if (push_reg && !dbnc.stable_level && is_long)
        begin
            long_next  = 1'b1;
            click_next = 1'b0;
            push_next  = 1'b0;
        end

        status.click_flag = click_next;
        status.long_flag  = long_next;
        status.press_held = push_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '0;
            push_reg  <= 1'b0;
            click_reg <= 1'b0;
            long_reg  <= 1'b0;
        end
        else if (step)
        begin
            hold_reg  <= hold_next;
            push_reg  <= push_next;
            click_reg <= click_next;
            long_reg  <= long_next;
        end
    end

endmodule

// File: design/key_debounce_click_long_press_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_click_long_press_unit
// Debounces a raw active-low key sample and classifies clicks and long presses.
// ----------------------------------------------------------------------------
// pipeline: input register then result register; a sample is registered in the input stage, then in the result stage
// throughput: one item per cycle while the result slot is free or being taken; both stages then advance together
// while a finished result waits, the input register takes a new sample only if it is empty
// reset: key released, counters and flags cleared, debounce 50 and long press 800 ticks
module key_debounce_click_long_press_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    kdclp_in_if.sink           key_ch,
    kdclp_out_if.source        result_ch,
    kdclp_cfg_if.sink          cfg
);
    import kdclp_pkg::*;

    cfg_data_t debounce_ticks_reg;
    cfg_data_t long_press_ticks_reg;

    logic s1_valid_reg;
    logic s1_key_reg;
    logic s1_ack_click_reg;
    logic s1_ack_long_reg;

    logic out_valid_reg;
    logic click_reg;
    logic long_reg;
    logic stable_reg;
    logic ready_pulse_reg;
    logic held_reg;

    logic advance;
    logic step;

    dbnc_status_t  dbnc_status;
    press_status_t press_status;

    // both stages move together whenever the result slot is free or being taken
    assign advance      = !out_valid_reg || result_ch.ready;
    assign step         = advance && s1_valid_reg;
    assign key_ch.ready = !s1_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= DEBOUNCE_TICKS_RST;
            long_press_ticks_reg <= LONG_PRESS_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg.data;
                REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg.data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (key_ch.ready)
            s1_valid_reg <= key_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (key_ch.valid && key_ch.ready)
        begin
            s1_key_reg       <= key_ch.key_level;
            s1_ack_click_reg <= key_ch.ack_click;
            s1_ack_long_reg  <= key_ch.ack_long;
        end
    end

    kdclp_debounce #(
        .CountWidth (COUNT_WIDTH)
    ) u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .raw            (s1_key_reg),
        .debounce_ticks (debounce_ticks_reg),
        .status         (dbnc_status)
    );

    kdclp_press #(
        .CountWidth (COUNT_WIDTH)
    ) u_press (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .dbnc             (dbnc_status),
        .ack_click        (s1_ack_click_reg),
        .ack_long         (s1_ack_long_reg),
        .long_press_ticks (long_press_ticks_reg),
        .status           (press_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            click_reg       <= press_status.click_flag;
            long_reg        <= press_status.long_flag;
            held_reg        <= press_status.press_held;
            stable_reg      <= dbnc_status.stable_level;
            ready_pulse_reg <= dbnc_status.level_ready;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.click_flag   = click_reg;
    assign result_ch.long_flag    = long_reg;
    assign result_ch.stable_level = stable_reg;
    assign result_ch.level_ready  = ready_pulse_reg;
    assign result_ch.press_held   = held_reg;

endmodule
